[hw/rtl/unp_pkg.sv]
// Shared types, constants and helpers of the UBX NAV-PVT frame parser.
package unp_pkg;

    // Payload bytes captured per frame; the last one triggers the result.
    localparam int CAPTURE_BYTES = 68;
    localparam int OFF_W         = $clog2(CAPTURE_BYTES);
    localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(CAPTURE_BYTES - 1);

    // Depth of the queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SYNC_A = 8'hB5;
    localparam logic [7:0] SYNC_B = 8'h62;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_MATCH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_MATCH    = 1'b1;
    localparam logic [7:0] CLASS_MATCH_RESET = 8'h01;
    localparam logic [7:0] ID_MATCH_RESET    = 8'h07;

    // Payload offsets of the NAV-PVT fields.
    localparam int OFF_YEAR_LO = 4;
    localparam int OFF_YEAR_HI = 5;
    localparam int OFF_MONTH   = 6;
    localparam int OFF_VALID   = 11;
    localparam int OFF_FIX     = 20;
    localparam int OFF_NUM_SV  = 23;
    localparam int OFF_LON     = 24;
    localparam int OFF_LAT     = 28;
    localparam int OFF_HMSL    = 36;
    localparam int OFF_HACC    = 40;
    localparam int OFF_VACC    = 44;
    localparam int OFF_GSPEED  = 60;
    localparam int OFF_HEADMOT = 64;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    // One payload byte with its place in the frame.
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [7:0]       data;
    } t_beat;

    typedef struct packed {
        logic  valid;
        t_beat beat;
    } t_push;

    typedef struct packed {
        logic [55:0]        utc_date_time;
        logic [7:0]         valid_bits;
        logic [7:0]         fix_kind;
        logic [7:0]         sat_count;
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic signed [31:0] height_msl;
        logic [31:0]        horiz_accuracy;
        logic [31:0]        vert_accuracy;
        logic signed [31:0] gnd_speed;
        logic signed [31:0] motion_heading;
    } t_pvt;

    // A byte that breaks a frame header restarts the sync if it is itself the first sync byte (0xB5).
    function automatic t_phase phase_resync(input logic [7:0] b);
        return (b == SYNC_A) ? PH_SYNC2 : PH_HUNT;
    endfunction

endpackage

[hw/rtl/unp_if.sv]
// Valid/ready channel interfaces for the byte input and the NAV-PVT result.
interface unp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface unp_pvt_if;
    logic               valid;
    logic               ready;
    logic [55:0]        utc_date_time;
    logic [7:0]         valid_bits;
    logic [7:0]         fix_kind;
    logic [7:0]         sat_count;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] height_msl;
    logic [31:0]        horiz_accuracy;
    logic [31:0]        vert_accuracy;
    logic signed [31:0] gnd_speed;
    logic signed [31:0] motion_heading;

    modport source (
        output valid, output utc_date_time, output valid_bits, output fix_kind,
        output sat_count, output longitude, output latitude, output height_msl,
        output horiz_accuracy, output vert_accuracy, output gnd_speed,
        output motion_heading, input ready
    );
    modport sink (
        input valid, input utc_date_time, input valid_bits, input fix_kind,
        input sat_count, input longitude, input latitude, input height_msl,
        input horiz_accuracy, input vert_accuracy, input gnd_speed,
        input motion_heading, output ready
    );
endinterface

[hw/rtl/ubx_nav_pvt_frame_parser.sv]
// Top level of the UBX NAV-PVT frame parser: front end, byte queue and field assembler.
// Throughput: one byte beat per cycle, sustained while the result side keeps up.
// The closing payload byte is first written into the queue and then, once any previous
// result has been claimed, moved into the output register, which raises the result beat.
// Reset (synchronous, active low) returns the parser to sync hunting, empties the
// queue, drops any pending result and restores class 0x01 and id 0x07.
module ubx_nav_pvt_frame_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    unp_byte_if.sink                      i_rx,
    unp_pvt_if.source                     o_pvt,
    input  logic                          i_cfg_wr_en,
    input  logic [unp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data
);
    import unp_pkg::*;

    // The front end walks the header phases and tags every payload byte with its
    // offset. Only payload bytes enter the queue, but the input, header bytes
    // included, is held off when the queue is full, and only then.
    t_push w_push;
    t_push w_head;
    logic  w_full;
    logic  w_pop;

    unp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (w_full),
        .o_push       (w_push)
    );

    // The queue lets the front end keep accepting while a finished result
    // waits on the output side.
    unp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // The back end drops each byte into its field lane; the closing byte copies
    // the assembled fields into the output register, so the next frame can be
    // gathered while the result is still being taken.
    unp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_pvt   (o_pvt)
    );

endmodule

[hw/rtl/unp_front.sv]
// Front end: byte acceptance, sync hunt, header match and payload offset tracking.
module unp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    unp_byte_if.sink                      i_rx,
    input  logic                          i_cfg_wr_en,
    input  logic [unp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          i_queue_full,
    output unp_pkg::t_push                o_push
);
    import unp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [OFF_W-1:0] r_offset, n_offset;
    logic [7:0]       r_class_match;
    logic [7:0]       r_id_match;
    logic             w_accept;

    assign i_rx.ready = !i_queue_full;
    assign w_accept   = i_rx.valid && !i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_offset <= '0;
        end else begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_match <= CLASS_MATCH_RESET;
            r_id_match    <= ID_MATCH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_CLASS_MATCH: r_class_match <= i_cfg_data;
                CFG_ID_MATCH:    r_id_match    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_phase            = r_phase;
        n_offset           = r_offset;
        o_push.valid       = w_accept && (r_phase == PH_PAYLOAD);
        o_push.beat.offset = r_offset;
        o_push.beat.data   = i_rx.rx_byte;
        if (w_accept) begin
            case (r_phase)
                PH_SYNC2: begin
                    n_phase = (i_rx.rx_byte == SYNC_B) ? PH_CLASS : phase_resync(i_rx.rx_byte);
                end
                PH_CLASS: begin
                    n_phase = (i_rx.rx_byte == r_class_match) ? PH_ID
                                                              : phase_resync(i_rx.rx_byte);
                end
                PH_ID: begin
                    n_phase = (i_rx.rx_byte == r_id_match) ? PH_LEN_LO
                                                           : phase_resync(i_rx.rx_byte);
                end
                PH_LEN_LO: begin
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_phase  = PH_PAYLOAD;
                    n_offset = '0;
                end
                PH_PAYLOAD: begin
                    if (r_offset == LAST_OFF) begin
                        n_phase  = PH_HUNT;
                        n_offset = '0;
                    end else begin
                        n_offset = OFF_W'(r_offset + 1'b1);
                    end
                end
                default: begin
                    n_phase = phase_resync(i_rx.rx_byte);
                end
            endcase
        end
    end

endmodule

[hw/rtl/unp_queue.sv]
// Short FIFO of payload bytes between the front end and the field assembler.
module unp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  unp_pkg::t_push i_push,
    output logic           o_full,
    output unp_pkg::t_push o_head,
    input  logic           i_pop
);
    import unp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_beat            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_wr        = i_push.valid && !o_full;
    assign w_rd        = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.beat  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= PTR_W'(r_wptr + 1'b1);
            end
            if (w_rd) begin
                r_rptr <= PTR_W'(r_rptr + 1'b1);
            end
            if (w_wr && !w_rd) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (w_rd && !w_wr) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wptr] <= i_push.beat;
        end
    end

endmodule

[hw/rtl/unp_back.sv]
// Back end: gathers the NAV-PVT fields from payload bytes and holds the result beat.
module unp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  unp_pkg::t_push i_head,
    output logic           o_pop,
    unp_pvt_if.source      o_pvt
);
    import unp_pkg::*;

    t_pvt             r_cap, n_cap;
    t_pvt             r_out;
    logic             r_out_valid;
    logic             w_last;
    logic [OFF_W-1:0] w_off;
    logic [7:0]       w_data;

    assign w_off  = i_head.beat.offset;
    assign w_data = i_head.beat.data;
    assign w_last = (w_off == LAST_OFF);
    // A closing byte waits while the previous result is still unclaimed.
    assign o_pop  = i_head.valid && (!w_last || !r_out_valid || o_pvt.ready);

    // Lane write of the current byte into the field it belongs to.
    always_comb begin
        n_cap = r_cap;
        if (w_off == OFF_W'(OFF_YEAR_LO)) n_cap.utc_date_time[47:40] = w_data;
        if (w_off == OFF_W'(OFF_YEAR_HI)) n_cap.utc_date_time[55:48] = w_data;
        for (int k = 0; k < 5; k++) begin
            if (w_off == OFF_W'(OFF_MONTH + k)) n_cap.utc_date_time[32 - 8*k +: 8] = w_data;
        end
        if (w_off == OFF_W'(OFF_VALID))  n_cap.valid_bits  = w_data;
        if (w_off == OFF_W'(OFF_FIX))    n_cap.fix_kind    = w_data;
        if (w_off == OFF_W'(OFF_NUM_SV)) n_cap.sat_count   = w_data;
        for (int k = 0; k < 4; k++) begin
            if (w_off == OFF_W'(OFF_LON + k))     n_cap.longitude[8*k +: 8]      = w_data;
            if (w_off == OFF_W'(OFF_LAT + k))     n_cap.latitude[8*k +: 8]       = w_data;
            if (w_off == OFF_W'(OFF_HMSL + k))    n_cap.height_msl[8*k +: 8]     = w_data;
            if (w_off == OFF_W'(OFF_HACC + k))    n_cap.horiz_accuracy[8*k +: 8] = w_data;
            if (w_off == OFF_W'(OFF_VACC + k))    n_cap.vert_accuracy[8*k +: 8]  = w_data;
            if (w_off == OFF_W'(OFF_GSPEED + k))  n_cap.gnd_speed[8*k +: 8]      = w_data;
            if (w_off == OFF_W'(OFF_HEADMOT + k)) n_cap.motion_heading[8*k +: 8] = w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_last) begin
            r_out_valid <= 1'b1;
        end else if (o_pvt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cap <= n_cap;
            if (w_last) begin
                r_out <= n_cap;
            end
        end
    end

    assign o_pvt.valid          = r_out_valid;
    assign o_pvt.utc_date_time  = r_out.utc_date_time;
    assign o_pvt.valid_bits     = r_out.valid_bits;
    assign o_pvt.fix_kind       = r_out.fix_kind;
    assign o_pvt.sat_count      = r_out.sat_count;
    assign o_pvt.longitude      = r_out.longitude;
    assign o_pvt.latitude       = r_out.latitude;
    assign o_pvt.height_msl     = r_out.height_msl;
    assign o_pvt.horiz_accuracy = r_out.horiz_accuracy;
    assign o_pvt.vert_accuracy  = r_out.vert_accuracy;
    assign o_pvt.gnd_speed      = r_out.gnd_speed;
    assign o_pvt.motion_heading = r_out.motion_heading;

endmodule
